### rtl/i2cbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package i2cbm_pkg;

  // Bus primitive being run; codes match the command codes that start them.
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_SEND  = 3'd3,
    OP_RECV  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } op_t;

  // Command codes on the input word; any other code acts as a tick.
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_SEND  = 3'd3;
  localparam logic [2:0] CMD_RECV  = 3'd4;
  localparam logic [2:0] CMD_SACK  = 3'd5;
  localparam logic [2:0] CMD_RACK  = 3'd6;

  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
  localparam logic [2:0] TOP_BIT        = 3'd7;
  localparam logic [7:0] HALF_PERIOD_RST = 8'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       rejected;
  } result_t;

  // Status of the output queue seen by the top level.
  typedef struct packed {
    logic       full;
    logic       empty;
  } q_stat_t;

endpackage
`default_nettype wire

### rtl/i2c_bit_level_master_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Signals                          Word
// --------  -------------------------------  -------------------------------
// in        in_valid / in_ready / in_data    item_t: cmd, tx_byte, ack, sda
// out       out_valid / out_ready / out_data result_t: pins, status, rx, ack
// cfg       cfg_we / cfg_wdata               half_period_ticks, no wait
//
// Each accepted word is handled in the cycle it is accepted: the bus state
// advances at that edge and one result word lands in a two-entry output queue,
// whose oldest entry shows on out_data. A new word can be taken every cycle;
// in_ready drops only while both queue entries hold results not yet taken.
// Reset (synchronous, rst high) leaves SCL and SDA high, SDA driven, the bus
// idle, the half period at 5 ticks and the queue empty.
module i2c_bit_level_master_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire i2cbm_pkg::item_t    in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output i2cbm_pkg::result_t       out_data
);

  logic               step;
  logic               pop;
  i2cbm_pkg::result_t res;
  i2cbm_pkg::q_stat_t q_stat;

  // take a word whenever the queue has room
  assign in_ready  = ~q_stat.full;
  assign step      = in_valid & in_ready;
  assign out_valid = ~q_stat.empty;
  assign pop       = out_valid & out_ready;

  // bus sequencer: state plus single-pass next-state logic
  i2cbm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (in_data),
    .res       (res)
  );

  // result queue decouples the consumer from the sequencer
  i2cbm_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (res),
    .pop       (pop),
    .head      (out_data),
    .stat      (q_stat)
  );

`ifndef ASSERT_OFF
  // a finished primitive leaves the bus idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |-> !res.busy_res)
    else $error("done result still busy");

  // a rejected command never changes the busy state
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    step && res.rejected |-> res.busy_res && !res.done_res)
    else $error("reject outside busy");

  // input stalls only while results are waiting
  a_stall_out: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty queue");

  // an accepted word always yields a pending result next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted word produced no result");
`endif

endmodule
`default_nettype wire

### rtl/i2cbm_core.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cbm_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata,
  input  wire logic              step,
  input  wire i2cbm_pkg::item_t  item,
  output i2cbm_pkg::result_t     res
);

  logic [7:0]     half_period;
  i2cbm_pkg::op_t operation, operation_next;
  logic           phase, phase_next;
  logic [3:0]     bit_index, bit_index_next;
  logic [7:0]     wait_count, wait_count_next;
  logic [7:0]     shift_reg, shift_reg_next;
  logic [7:0]     rx_reg, rx_reg_next;
  logic           scl_reg, scl_reg_next;
  logic           sda_reg, sda_reg_next;
  logic           sda_dir_in, sda_dir_in_next;
  logic           ack_reg, ack_reg_next;

  logic           is_cmd;
  logic           fin;
  logic           done;
  logic           rej;
  logic [7:0]     reload;
  logic [3:0]     idx_inc;

  always_comb begin
    operation_next  = operation;
    phase_next      = phase;
    bit_index_next  = bit_index;
    wait_count_next = wait_count;
    shift_reg_next  = shift_reg;
    rx_reg_next     = rx_reg;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    sda_dir_in_next = sda_dir_in;
    ack_reg_next    = ack_reg;
    done            = 1'b0;
    rej             = 1'b0;
    fin             = 1'b0;
    reload          = (half_period == 8'd0) ? 8'd1 : half_period;
    idx_inc         = bit_index + 4'd1;

    unique case (item.cmd) inside
      i2cbm_pkg::CMD_START, i2cbm_pkg::CMD_STOP, i2cbm_pkg::CMD_SEND,
      i2cbm_pkg::CMD_RECV, i2cbm_pkg::CMD_SACK, i2cbm_pkg::CMD_RACK: begin
        is_cmd = 1'b1;
      end
      default: begin
        is_cmd = 1'b0;
      end
    endcase

    if (!is_cmd) begin
      if (operation != i2cbm_pkg::OP_IDLE) begin
        if (wait_count > 8'd1) begin
          wait_count_next = wait_count - 8'd1;
        end else begin
          if (!phase) begin
            // first half of a step: SDA falls for start, else SCL rises
            if (operation == i2cbm_pkg::OP_START) begin
              sda_reg_next = 1'b0;
            end else begin
              scl_reg_next = 1'b1;
            end
            phase_next = 1'b1;
          end else begin
            unique case (operation)
              i2cbm_pkg::OP_START, i2cbm_pkg::OP_SACK: begin
                scl_reg_next = 1'b0;
                fin          = 1'b1;
              end
              i2cbm_pkg::OP_STOP: begin
                sda_reg_next = 1'b1;
                fin          = 1'b1;
              end
              i2cbm_pkg::OP_RACK: begin
                ack_reg_next = item.sda_in;
                scl_reg_next = 1'b0;
                fin          = 1'b1;
              end
              i2cbm_pkg::OP_SEND: begin
                scl_reg_next   = 1'b0;
                bit_index_next = idx_inc;
                if (idx_inc >= i2cbm_pkg::BITS_PER_BYTE) begin
                  fin = 1'b1;
                end else begin
                  sda_reg_next = shift_reg[i2cbm_pkg::TOP_BIT - idx_inc[2:0]];
                  phase_next   = 1'b0;
                end
              end
              i2cbm_pkg::OP_RECV: begin
                // sample at the end of the SCL-high half, MSB first
                if (item.sda_in) begin
                  rx_reg_next[i2cbm_pkg::TOP_BIT - bit_index[2:0]] = 1'b1;
                end
                scl_reg_next   = 1'b0;
                bit_index_next = idx_inc;
                if (idx_inc >= i2cbm_pkg::BITS_PER_BYTE) begin
                  fin = 1'b1;
                end else begin
                  phase_next = 1'b0;
                end
              end
              default: begin
                fin = 1'b1;
              end
            endcase
          end
          if (fin) begin
            operation_next  = i2cbm_pkg::OP_IDLE;
            phase_next      = 1'b0;
            wait_count_next = 8'd0;
            done            = 1'b1;
          end else begin
            wait_count_next = reload;
          end
        end
      end
    end else if (operation != i2cbm_pkg::OP_IDLE) begin
      rej = 1'b1;
    end else begin
      operation_next  = i2cbm_pkg::op_t'(item.cmd);
      phase_next      = 1'b0;
      bit_index_next  = 4'd0;
      wait_count_next = reload;
      unique case (item.cmd)
        i2cbm_pkg::CMD_START: begin
          sda_dir_in_next = 1'b0;
          scl_reg_next    = 1'b1;
          sda_reg_next    = 1'b1;
        end
        i2cbm_pkg::CMD_STOP: begin
          sda_dir_in_next = 1'b0;
          scl_reg_next    = 1'b0;
          sda_reg_next    = 1'b0;
        end
        i2cbm_pkg::CMD_SEND: begin
          sda_dir_in_next = 1'b0;
          scl_reg_next    = 1'b0;
          shift_reg_next  = item.tx_byte;
          sda_reg_next    = item.tx_byte[i2cbm_pkg::TOP_BIT];
        end
        i2cbm_pkg::CMD_RECV: begin
          sda_dir_in_next = 1'b1;
          scl_reg_next    = 1'b0;
          rx_reg_next     = 8'd0;
        end
        i2cbm_pkg::CMD_SACK: begin
          sda_dir_in_next = 1'b0;
          scl_reg_next    = 1'b0;
          sda_reg_next    = item.ack_level;
        end
        default: begin
          sda_dir_in_next = 1'b1;
          scl_reg_next    = 1'b0;
        end
      endcase
    end

    res.scl_level    = scl_reg_next;
    res.sda_level    = sda_dir_in_next | sda_reg_next;
    res.sda_released = sda_dir_in_next;
    res.busy_res     = (operation_next != i2cbm_pkg::OP_IDLE);
    res.done_res     = done;
    res.rx_byte      = rx_reg_next;
    res.ack_seen     = ack_reg_next;
    res.rejected     = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cbm_pkg::HALF_PERIOD_RST;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation  <= i2cbm_pkg::OP_IDLE;
      phase      <= 1'b0;
      bit_index  <= 4'd0;
      wait_count <= 8'd0;
      shift_reg  <= 8'd0;
      rx_reg     <= 8'd0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      sda_dir_in <= 1'b0;
      ack_reg    <= 1'b0;
    end else if (step) begin
      operation  <= operation_next;
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      wait_count <= wait_count_next;
      shift_reg  <= shift_reg_next;
      rx_reg     <= rx_reg_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      sda_dir_in <= sda_dir_in_next;
      ack_reg    <= ack_reg_next;
    end
  end

endmodule
`default_nettype wire

### rtl/i2cbm_out_q.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cbm_out_q (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire i2cbm_pkg::result_t  push_data,
  input  wire logic                pop,
  output i2cbm_pkg::result_t       head,
  output i2cbm_pkg::q_stat_t       stat
);

  i2cbm_pkg::result_t slot [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  assign head       = slot[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire
